// ===== src/bbma_pkg.sv =====
`default_nettype none
package bbma_pkg;

    localparam int ACC_W   = 112;
    localparam int QUO_W   = 58;
    localparam int DEN_W   = 48;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 39;
    localparam int COV_W   = 40;
    localparam int THIRD_W = 58;
    localparam int UOP_N   = 31;

    typedef struct packed {
        logic [15:0] cnt;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [47:0] sxx;
        logic [47:0] sxy;
        logic [47:0] syy;
        logic [63:0] sxxx;
        logic [63:0] sxxy;
        logic [63:0] sxyy;
        logic [63:0] syyy;
    } sums_t;

    typedef struct packed {
        logic                 done;
        logic [MEAN_W-1:0]    mean_first;
        logic [MEAN_W-1:0]    mean_second;
        logic [VAR_W-1:0]     var_first;
        logic [COV_W-1:0]     covariance;
        logic [VAR_W-1:0]     var_second;
        logic [THIRD_W-1:0]   third_first;
        logic [THIRD_W-1:0]   third_mixed_ffs;
        logic [THIRD_W-1:0]   third_mixed_fss;
        logic [THIRD_W-1:0]   third_second;
    } eng_res_t;

    typedef logic [4:0] opsel_t;
    typedef logic [4:0] dst_t;
    typedef logic [1:0] den_t;
    typedef logic [4:0] upc_t;

    localparam opsel_t OP_ONE  = 5'd0;
    localparam opsel_t OP_N    = 5'd1;
    localparam opsel_t OP_N3   = 5'd2;
    localparam opsel_t OP_NN   = 5'd3;
    localparam opsel_t OP_NX   = 5'd4;
    localparam opsel_t OP_NY   = 5'd5;
    localparam opsel_t OP_N3X  = 5'd6;
    localparam opsel_t OP_N3Y  = 5'd7;
    localparam opsel_t OP_X    = 5'd8;
    localparam opsel_t OP_Y    = 5'd9;
    localparam opsel_t OP_XX   = 5'd10;
    localparam opsel_t OP_XY   = 5'd11;
    localparam opsel_t OP_YY   = 5'd12;
    localparam opsel_t OP_SXX  = 5'd13;
    localparam opsel_t OP_SXY  = 5'd14;
    localparam opsel_t OP_SYY  = 5'd15;
    localparam opsel_t OP_SXXX = 5'd16;
    localparam opsel_t OP_SXXY = 5'd17;
    localparam opsel_t OP_SXYY = 5'd18;
    localparam opsel_t OP_SYYY = 5'd19;

    localparam dst_t D_NN   = 5'd0;
    localparam dst_t D_NNN  = 5'd1;
    localparam dst_t D_NX   = 5'd2;
    localparam dst_t D_NY   = 5'd3;
    localparam dst_t D_N3X  = 5'd4;
    localparam dst_t D_N3Y  = 5'd5;
    localparam dst_t D_XX   = 5'd6;
    localparam dst_t D_XY   = 5'd7;
    localparam dst_t D_YY   = 5'd8;
    localparam dst_t D_MX   = 5'd9;
    localparam dst_t D_MY   = 5'd10;
    localparam dst_t D_VX   = 5'd11;
    localparam dst_t D_CV   = 5'd12;
    localparam dst_t D_VY   = 5'd13;
    localparam dst_t D_T3X  = 5'd14;
    localparam dst_t D_TXXY = 5'd15;
    localparam dst_t D_TXYY = 5'd16;
    localparam dst_t D_T3Y  = 5'd17;

    localparam den_t DEN_N   = 2'd0;
    localparam den_t DEN_NN  = 2'd1;
    localparam den_t DEN_NNN = 2'd2;

    typedef struct packed {
        opsel_t a;
        opsel_t b;
        logic   sub;
        logic   dbl;
        logic   last;
        dst_t   dst;
        den_t   den;
    } uop_t;

    function automatic uop_t mk(input opsel_t a, input opsel_t b, input logic sub,
                                input logic dbl, input logic last, input dst_t dst,
                                input den_t den);
        uop_t u;
        u.a    = a;
        u.b    = b;
        u.sub  = sub;
        u.dbl  = dbl;
        u.last = last;
        u.dst  = dst;
        u.den  = den;
        return u;
    endfunction

    // one term per step: acc +/- (a * b) << dbl, last step of a group lands in dst
    function automatic uop_t uop_at(input upc_t pc);
        uop_t u;
        u = mk(OP_ONE, OP_ONE, 1'b0, 1'b0, 1'b0, D_NN, DEN_N);
        case (pc)
            5'd0:  u = mk(OP_N,   OP_N,    1'b0, 1'b0, 1'b1, D_NN,   DEN_N);
            5'd1:  u = mk(OP_NN,  OP_N,    1'b0, 1'b0, 1'b1, D_NNN,  DEN_N);
            5'd2:  u = mk(OP_N,   OP_X,    1'b0, 1'b0, 1'b1, D_NX,   DEN_N);
            5'd3:  u = mk(OP_N,   OP_Y,    1'b0, 1'b0, 1'b1, D_NY,   DEN_N);
            5'd4:  u = mk(OP_N3,  OP_X,    1'b0, 1'b0, 1'b1, D_N3X,  DEN_N);
            5'd5:  u = mk(OP_N3,  OP_Y,    1'b0, 1'b0, 1'b1, D_N3Y,  DEN_N);
            5'd6:  u = mk(OP_X,   OP_X,    1'b0, 1'b0, 1'b1, D_XX,   DEN_N);
            5'd7:  u = mk(OP_X,   OP_Y,    1'b0, 1'b0, 1'b1, D_XY,   DEN_N);
            5'd8:  u = mk(OP_Y,   OP_Y,    1'b0, 1'b0, 1'b1, D_YY,   DEN_N);
            5'd9:  u = mk(OP_X,   OP_ONE,  1'b0, 1'b0, 1'b1, D_MX,   DEN_N);
            5'd10: u = mk(OP_Y,   OP_ONE,  1'b0, 1'b0, 1'b1, D_MY,   DEN_N);
            5'd11: u = mk(OP_N,   OP_SXX,  1'b0, 1'b0, 1'b0, D_VX,   DEN_NN);
            5'd12: u = mk(OP_XX,  OP_ONE,  1'b1, 1'b0, 1'b1, D_VX,   DEN_NN);
            5'd13: u = mk(OP_N,   OP_SXY,  1'b0, 1'b0, 1'b0, D_CV,   DEN_NN);
            5'd14: u = mk(OP_XY,  OP_ONE,  1'b1, 1'b0, 1'b1, D_CV,   DEN_NN);
            5'd15: u = mk(OP_N,   OP_SYY,  1'b0, 1'b0, 1'b0, D_VY,   DEN_NN);
            5'd16: u = mk(OP_YY,  OP_ONE,  1'b1, 1'b0, 1'b1, D_VY,   DEN_NN);
            5'd17: u = mk(OP_NN,  OP_SXXX, 1'b0, 1'b0, 1'b0, D_T3X,  DEN_NNN);
            5'd18: u = mk(OP_N3X, OP_SXX,  1'b1, 1'b0, 1'b0, D_T3X,  DEN_NNN);
            5'd19: u = mk(OP_XX,  OP_X,    1'b0, 1'b1, 1'b1, D_T3X,  DEN_NNN);
            5'd20: u = mk(OP_NN,  OP_SXXY, 1'b0, 1'b0, 1'b0, D_TXXY, DEN_NNN);
            5'd21: u = mk(OP_NX,  OP_SXY,  1'b1, 1'b1, 1'b0, D_TXXY, DEN_NNN);
            5'd22: u = mk(OP_NY,  OP_SXX,  1'b1, 1'b0, 1'b0, D_TXXY, DEN_NNN);
            5'd23: u = mk(OP_XX,  OP_Y,    1'b0, 1'b1, 1'b1, D_TXXY, DEN_NNN);
            5'd24: u = mk(OP_NN,  OP_SXYY, 1'b0, 1'b0, 1'b0, D_TXYY, DEN_NNN);
            5'd25: u = mk(OP_NY,  OP_SXY,  1'b1, 1'b1, 1'b0, D_TXYY, DEN_NNN);
            5'd26: u = mk(OP_NX,  OP_SYY,  1'b1, 1'b0, 1'b0, D_TXYY, DEN_NNN);
            5'd27: u = mk(OP_YY,  OP_X,    1'b0, 1'b1, 1'b1, D_TXYY, DEN_NNN);
            5'd28: u = mk(OP_NN,  OP_SYYY, 1'b0, 1'b0, 1'b0, D_T3Y,  DEN_NNN);
            5'd29: u = mk(OP_N3Y, OP_SYY,  1'b1, 1'b0, 1'b0, D_T3Y,  DEN_NNN);
            5'd30: u = mk(OP_YY,  OP_Y,    1'b0, 1'b1, 1'b1, D_T3Y,  DEN_NNN);
            default: u = mk(OP_ONE, OP_ONE, 1'b0, 1'b0, 1'b0, D_NN, DEN_N);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== src/bbma_ram.sv =====
`default_nettype none
module bbma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/bbma_div.sv =====
`default_nettype none
module bbma_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bbma_pkg::ACC_W-1:0]    num,
    input  wire logic [bbma_pkg::DEN_W-1:0]    den,
    output logic                               done,
    output logic      [bbma_pkg::QUO_W-1:0]    quot
);

    localparam int CW = $clog2(bbma_pkg::QUO_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          neg_reg;
    logic [bbma_pkg::DEN_W-1:0]    den_reg;
    logic [bbma_pkg::DEN_W-1:0]    rem_reg;
    logic [bbma_pkg::QUO_W-1:0]    low_reg;
    logic [bbma_pkg::QUO_W-1:0]    q_reg;
    logic [bbma_pkg::ACC_W-1:0]    mag;
    logic [bbma_pkg::DEN_W:0]      trial;
    logic                          ge;

    assign mag   = num[bbma_pkg::ACC_W-1] ? ((~num) + bbma_pkg::ACC_W'(1)) : num;
    assign trial = {rem_reg, low_reg[bbma_pkg::QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(bbma_pkg::QUO_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(bbma_pkg::QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[bbma_pkg::ACC_W-1];
            den_reg <= den;
            rem_reg <= bbma_pkg::DEN_W'(mag >> bbma_pkg::QUO_W);
            low_reg <= mag[bbma_pkg::QUO_W-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? bbma_pkg::DEN_W'(trial - {1'b0, den_reg})
                          : bbma_pkg::DEN_W'(trial);
            low_reg <= {low_reg[bbma_pkg::QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[bbma_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? ((~q_reg) + bbma_pkg::QUO_W'(1)) : q_reg;

endmodule
`default_nettype wire

// ===== src/bbma_engine.sv =====
`default_nettype none
module bbma_engine #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire bbma_pkg::sums_t   sums,
    output bbma_pkg::eng_res_t     res
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_MUL  = 2'd1;
    localparam logic [1:0] E_DIV  = 2'd2;

    logic [1:0]                    st_reg;
    bbma_pkg::upc_t                pc_reg;
    logic [2:0]                    ph_reg;
    logic                          done_reg;
    logic [bbma_pkg::ACC_W-1:0]    acc_reg;
    logic [bbma_pkg::ACC_W-1:0]    acc_next;
    logic [63:0]                   prod_reg;
    logic [1:0]                    sh_reg;

    logic [31:0] nn_reg;
    logic [47:0] nnn_reg;
    logic [47:0] nx_reg;
    logic [47:0] ny_reg;
    logic [49:0] n3x_reg;
    logic [49:0] n3y_reg;
    logic [63:0] xx_reg;
    logic [63:0] xy_reg;
    logic [63:0] yy_reg;

    logic [bbma_pkg::MEAN_W-1:0]  mx_reg;
    logic [bbma_pkg::MEAN_W-1:0]  my_reg;
    logic [bbma_pkg::VAR_W-1:0]   vx_reg;
    logic [bbma_pkg::COV_W-1:0]   cv_reg;
    logic [bbma_pkg::VAR_W-1:0]   vy_reg;
    logic [bbma_pkg::THIRD_W-1:0] t3x_reg;
    logic [bbma_pkg::THIRD_W-1:0] txxy_reg;
    logic [bbma_pkg::THIRD_W-1:0] txyy_reg;
    logic [bbma_pkg::THIRD_W-1:0] t3y_reg;

    bbma_pkg::uop_t                uop;
    logic [17:0]                   n3;
    logic [63:0]                   a_val;
    logic [63:0]                   b_val;
    logic [31:0]                   a_chunk;
    logic [31:0]                   b_chunk;
    logic [bbma_pkg::ACC_W-1:0]    term;
    logic                          dst_out;
    logic                          step_end;
    logic                          div_start;
    logic [bbma_pkg::DEN_W-1:0]    den;
    logic                          div_done;
    logic [bbma_pkg::QUO_W-1:0]    quot;

    function automatic logic [63:0] opnd(input bbma_pkg::opsel_t sel);
        logic [63:0] v;
        case (sel)
            bbma_pkg::OP_ONE:  v = 64'd1;
            bbma_pkg::OP_N:    v = 64'(sums.cnt);
            bbma_pkg::OP_N3:   v = 64'(n3);
            bbma_pkg::OP_NN:   v = 64'(nn_reg);
            bbma_pkg::OP_NX:   v = 64'(nx_reg);
            bbma_pkg::OP_NY:   v = 64'(ny_reg);
            bbma_pkg::OP_N3X:  v = 64'(n3x_reg);
            bbma_pkg::OP_N3Y:  v = 64'(n3y_reg);
            bbma_pkg::OP_X:    v = 64'(sums.sx);
            bbma_pkg::OP_Y:    v = 64'(sums.sy);
            bbma_pkg::OP_XX:   v = xx_reg;
            bbma_pkg::OP_XY:   v = xy_reg;
            bbma_pkg::OP_YY:   v = yy_reg;
            bbma_pkg::OP_SXX:  v = 64'(sums.sxx);
            bbma_pkg::OP_SXY:  v = 64'(sums.sxy);
            bbma_pkg::OP_SYY:  v = 64'(sums.syy);
            bbma_pkg::OP_SXXX: v = sums.sxxx;
            bbma_pkg::OP_SXXY: v = sums.sxxy;
            bbma_pkg::OP_SXYY: v = sums.sxyy;
            bbma_pkg::OP_SYYY: v = sums.syyy;
            default:           v = 64'd0;
        endcase
        return v;
    endfunction

    assign uop     = bbma_pkg::uop_at(pc_reg);
    assign n3      = {2'b00, sums.cnt} + {1'b0, sums.cnt, 1'b0};
    assign a_val   = opnd(uop.a);
    assign b_val   = opnd(uop.b);
    assign a_chunk = ph_reg[0] ? a_val[63:32] : a_val[31:0];
    assign b_chunk = ph_reg[1] ? b_val[63:32] : b_val[31:0];

    always_comb begin
        term = bbma_pkg::ACC_W'(prod_reg) << {sh_reg, 5'd0};
        if (uop.dbl) begin
            term = {term[bbma_pkg::ACC_W-2:0], 1'b0};
        end
        acc_next = uop.sub ? (acc_reg - term) : (acc_reg + term);
    end

    assign dst_out   = (uop.dst >= bbma_pkg::D_MX);
    assign step_end  = (st_reg == E_MUL) && (ph_reg == 3'd5);
    assign div_start = step_end && uop.last && dst_out;

    always_comb begin
        case (uop.den)
            bbma_pkg::DEN_N:   den = bbma_pkg::DEN_W'(sums.cnt);
            bbma_pkg::DEN_NN:  den = bbma_pkg::DEN_W'(nn_reg);
            bbma_pkg::DEN_NNN: den = nnn_reg;
            default:           den = bbma_pkg::DEN_W'(sums.cnt);
        endcase
    end

    bbma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_reg << FRAC_BITS),
        .den     (den),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= E_IDLE;
            pc_reg   <= '0;
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (st_reg == E_DIV) && div_done
                        && (pc_reg == 5'(bbma_pkg::UOP_N - 1));
            case (st_reg)
                E_IDLE: begin
                    if (start) begin
                        st_reg <= E_MUL;
                        pc_reg <= '0;
                        ph_reg <= '0;
                    end
                end
                E_MUL: begin
                    if (ph_reg == 3'd5) begin
                        ph_reg <= '0;
                        if (div_start) begin
                            st_reg <= E_DIV;
                        end else begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                E_DIV: begin
                    if (div_done) begin
                        if (pc_reg == 5'(bbma_pkg::UOP_N - 1)) begin
                            st_reg <= E_IDLE;
                        end else begin
                            st_reg <= E_MUL;
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                end
                default: st_reg <= E_IDLE;
            endcase
        end
    end

    // chunk products issue in phases 0-3 and land in the accumulator in the cycle after, in phases 1-4
    always_ff @(posedge aclk) begin
        if (st_reg == E_IDLE) begin
            acc_reg <= '0;
        end else if (st_reg == E_MUL) begin
            if (ph_reg <= 3'd3) begin
                prod_reg <= a_chunk * b_chunk;
                sh_reg   <= {1'b0, ph_reg[0]} + {1'b0, ph_reg[1]};
            end
            if (ph_reg >= 3'd1 && ph_reg <= 3'd4) begin
                acc_reg <= acc_next;
            end
            if (step_end && uop.last) begin
                acc_reg <= '0;
                case (uop.dst)
                    bbma_pkg::D_NN:  nn_reg  <= acc_reg[31:0];
                    bbma_pkg::D_NNN: nnn_reg <= acc_reg[47:0];
                    bbma_pkg::D_NX:  nx_reg  <= acc_reg[47:0];
                    bbma_pkg::D_NY:  ny_reg  <= acc_reg[47:0];
                    bbma_pkg::D_N3X: n3x_reg <= acc_reg[49:0];
                    bbma_pkg::D_N3Y: n3y_reg <= acc_reg[49:0];
                    bbma_pkg::D_XX:  xx_reg  <= acc_reg[63:0];
                    bbma_pkg::D_XY:  xy_reg  <= acc_reg[63:0];
                    bbma_pkg::D_YY:  yy_reg  <= acc_reg[63:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == E_DIV && div_done) begin
            case (uop.dst)
                bbma_pkg::D_MX:   mx_reg   <= quot[bbma_pkg::MEAN_W-1:0];
                bbma_pkg::D_MY:   my_reg   <= quot[bbma_pkg::MEAN_W-1:0];
                bbma_pkg::D_VX:   vx_reg   <= quot[bbma_pkg::VAR_W-1:0];
                bbma_pkg::D_CV:   cv_reg   <= quot[bbma_pkg::COV_W-1:0];
                bbma_pkg::D_VY:   vy_reg   <= quot[bbma_pkg::VAR_W-1:0];
                bbma_pkg::D_T3X:  t3x_reg  <= quot[bbma_pkg::THIRD_W-1:0];
                bbma_pkg::D_TXXY: txxy_reg <= quot[bbma_pkg::THIRD_W-1:0];
                bbma_pkg::D_TXYY: txyy_reg <= quot[bbma_pkg::THIRD_W-1:0];
                bbma_pkg::D_T3Y:  t3y_reg  <= quot[bbma_pkg::THIRD_W-1:0];
                default: ;
            endcase
        end
    end

    assign res.done            = done_reg;
    assign res.mean_first      = mx_reg;
    assign res.mean_second     = my_reg;
    assign res.var_first       = vx_reg;
    assign res.covariance      = cv_reg;
    assign res.var_second      = vy_reg;
    assign res.third_first     = t3x_reg;
    assign res.third_mixed_ffs = txxy_reg;
    assign res.third_mixed_fss = txyy_reg;
    assign res.third_second    = t3y_reg;

endmodule
`default_nettype wire

// ===== src/binned_bivariate_moment_accumulator_core.sv =====
`default_nettype none
// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  mode, bin, count_first, count_second
// m_       out  m_valid / m_ready  bin_empty, samples, means, variances, covariance, thirds
//
// accumulate beat: bin RAM read, square, cube, write back
// read beat: 31 terms on one shared 32x32 multiplier
//   plus 9 bit-serial divisions; an empty bin skips the engine
// after reset a clearing pass writes zeros over all BINS entries, s_ready low until it ends
// the output register holds one result while the next beat is taken in
module binned_bivariate_moment_accumulator_core #(
    parameter int BINS       = 1024,
    parameter int POP_BITS   = 16,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    input  wire logic [9:0]          s_bin,
    input  wire logic [15:0]         s_count_first,
    input  wire logic [15:0]         s_count_second,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_bin_empty,
    output logic [15:0]              m_samples,
    output logic [23:0]              m_mean_first,
    output logic [23:0]              m_mean_second,
    output logic [38:0]              m_var_first,
    output logic signed [39:0]       m_covariance,
    output logic [38:0]              m_var_second,
    output logic signed [57:0]       m_third_first,
    output logic signed [57:0]       m_third_mixed_ffs,
    output logic signed [57:0]       m_third_mixed_fss,
    output logic signed [57:0]       m_third_second
);

    localparam int          BIN_AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int          WORD_W   = $bits(bbma_pkg::sums_t);
    localparam logic [15:0] CNT_MAX  = 16'((1 << COUNT_BITS) - 1);
    localparam logic [15:0] POP_MASK = 16'((1 << POP_BITS) - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_A1    = 3'd2;
    localparam logic [2:0] S_A2    = 3'd3;
    localparam logic [2:0] S_A3    = 3'd4;
    localparam logic [2:0] S_R1    = 3'd5;
    localparam logic [2:0] S_RUN   = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    logic [2:0]            state_reg;
    logic [BIN_AW-1:0]     clr_addr_reg;
    logic [BIN_AW-1:0]     addr_reg;
    logic                  in_range_reg;
    logic                  empty_reg;
    logic [15:0]           x_reg;
    logic [15:0]           y_reg;
    logic [31:0]           xx_reg;
    logic [31:0]           xy_reg;
    logic [31:0]           yy_reg;
    logic [47:0]           xxx_reg;
    logic [47:0]           xxy_reg;
    logic [47:0]           xyy_reg;
    logic [47:0]           yyy_reg;
    bbma_pkg::sums_t       word_reg;
    bbma_pkg::sums_t       upd;
    bbma_pkg::eng_res_t    eng_res;
    logic                  m_valid_reg;

    logic                  accept;
    logic                  in_range;
    logic                  ram_we;
    logic                  ram_re;
    logic [BIN_AW-1:0]     ram_waddr;
    bbma_pkg::sums_t       ram_wdata;
    bbma_pkg::sums_t       ram_rdata;
    logic [WORD_W-1:0]     ram_rword;
    logic                  eng_start;
    logic                  load_out;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign in_range  = (32'(s_bin) < 32'(BINS));
    assign ram_re    = accept;
    assign eng_start = (state_reg == S_R1) && in_range_reg && (ram_rdata.cnt != 16'd0);
    assign load_out  = (state_reg == S_PUSH) && (!m_valid_reg || m_ready);
    assign ram_rdata = bbma_pkg::sums_t'(ram_rword);

    always_comb begin
        upd      = word_reg;
        upd.cnt  = word_reg.cnt + 16'd1;
        upd.sx   = word_reg.sx + 32'(x_reg);
        upd.sy   = word_reg.sy + 32'(y_reg);
        upd.sxx  = word_reg.sxx + 48'(xx_reg);
        upd.sxy  = word_reg.sxy + 48'(xy_reg);
        upd.syy  = word_reg.syy + 48'(yy_reg);
        upd.sxxx = word_reg.sxxx + 64'(xxx_reg);
        upd.sxxy = word_reg.sxxy + 64'(xxy_reg);
        upd.sxyy = word_reg.sxyy + 64'(xyy_reg);
        upd.syyy = word_reg.syyy + 64'(yyy_reg);
    end

    always_comb begin
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = (state_reg == S_A3) && (word_reg.cnt < CNT_MAX);
            ram_waddr = addr_reg;
            ram_wdata = upd;
        end
    end

    bbma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (BIN_AW'(s_bin)),
        .rdata (ram_rword)
    );

    bbma_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eng_start),
        .sums    (word_reg),
        .res     (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + BIN_AW'(1);
                    if (clr_addr_reg == BIN_AW'(BINS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (s_mode) begin
                            state_reg <= S_R1;
                        end else if (in_range) begin
                            state_reg <= S_A1;
                        end
                    end
                end
                S_A1:  state_reg <= S_A2;
                S_A2:  state_reg <= S_A3;
                S_A3:  state_reg <= S_IDLE;
                S_R1:  state_reg <= eng_start ? S_RUN : S_PUSH;
                S_RUN: begin
                    if (eng_res.done) begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (load_out) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg     <= BIN_AW'(s_bin);
            in_range_reg <= in_range;
            x_reg        <= s_count_first & POP_MASK;
            y_reg        <= s_count_second & POP_MASK;
        end
        if (state_reg == S_A1 || state_reg == S_R1) begin
            word_reg <= ram_rdata;
        end
        if (state_reg == S_R1) begin
            empty_reg <= !eng_start;
        end
        if (state_reg == S_A1) begin
            xx_reg <= 32'(x_reg) * 32'(x_reg);
            xy_reg <= 32'(x_reg) * 32'(y_reg);
            yy_reg <= 32'(y_reg) * 32'(y_reg);
        end
        if (state_reg == S_A2) begin
            xxx_reg <= 48'(xx_reg) * 48'(x_reg);
            xxy_reg <= 48'(xx_reg) * 48'(y_reg);
            xyy_reg <= 48'(xy_reg) * 48'(y_reg);
            yyy_reg <= 48'(yy_reg) * 48'(y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_bin_empty <= empty_reg;
            if (empty_reg) begin
                m_samples         <= '0;
                m_mean_first      <= '0;
                m_mean_second     <= '0;
                m_var_first       <= '0;
                m_covariance      <= '0;
                m_var_second      <= '0;
                m_third_first     <= '0;
                m_third_mixed_ffs <= '0;
                m_third_mixed_fss <= '0;
                m_third_second    <= '0;
            end else begin
                m_samples         <= word_reg.cnt;
                m_mean_first      <= eng_res.mean_first;
                m_mean_second     <= eng_res.mean_second;
                m_var_first       <= eng_res.var_first;
                m_covariance      <= eng_res.covariance;
                m_var_second      <= eng_res.var_second;
                m_third_first     <= eng_res.third_first;
                m_third_mixed_ffs <= eng_res.third_mixed_ffs;
                m_third_mixed_fss <= eng_res.third_mixed_fss;
                m_third_second    <= eng_res.third_second;
            end
        end
    end

    assign m_valid = m_valid_reg;

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("bin RAM read and write in one cycle");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_res.done |-> (state_reg == S_RUN))
        else $error("engine finished outside a read-out");

    a_wb_after_cube: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_CLEAR) |-> ($past(state_reg) == S_A2))
        else $error("write back without product stage");

endmodule
`default_nettype wire
